>>> rtl/utf8wt_pkg.sv
// Shared types and constants of the UTF-8 word tokenizer.
package utf8wt_pkg;

  // Decoder constants.
  localparam logic [7:0]  CONT_MASK  = 8'hC0;
  localparam logic [7:0]  CONT_CODE  = 8'h80;
  localparam logic [7:0]  LEAD2_MASK = 8'hE0;
  localparam logic [7:0]  LEAD2_CODE = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK = 8'hF0;
  localparam logic [7:0]  LEAD3_CODE = 8'hE0;
  localparam logic [7:0]  LEAD4_MASK = 8'hF8;
  localparam logic [7:0]  LEAD4_CODE = 8'hF0;
  localparam logic [7:0]  PAYLOAD_MASK = 8'h3F;

  // Character ranges.
  localparam logic [20:0] CYR_LO      = 21'h000400;
  localparam logic [20:0] CYR_HI      = 21'h0004FF;
  localparam logic [20:0] CYR_UP_LO   = 21'h000410;
  localparam logic [20:0] CYR_UP_HI   = 21'h00042F;
  localparam logic [20:0] CYR_IO_UP   = 21'h000401;
  localparam logic [20:0] CYR_IO_LOW  = 21'h000451;
  localparam logic [20:0] CASE_OFFSET = 21'h000020;
  localparam logic [20:0] ASCII_MAX   = 21'h00007F;

  // Most results one input beat can cause.
  localparam int unsigned MAX_RESULTS = 3;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_end;
    logic       text_end;
  } result_t;

  // All results of one input beat, first result in slot 0.
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [1:0]                cnt;
  } bundle_t;

endpackage

>>> rtl/utf8_word_tokenizer.sv
// Top level of the UTF-8 word tokenizer: decoder and result buffer.
//
//   Channel  Dir  tdata           tuser                           tlast
//   s_axis   in   in_byte[7:0]    -                               text_last
//   m_axis   out  out_byte[7:0]   byte_valid, token_end, text_end run_last
//
// An input beat is decoded in the cycle it is accepted; its results go
// into the result buffer and leave one per cycle while m_tready is high, so
// a beat holds the input until all its results (one to three) have left,
// and not when it causes none. The first result is offered in the cycle
// after the beat. The result buffer's drain sets the rate: a new beat is
// taken in the cycle the last buffered result leaves, or at once when the
// buffer is empty. rst is synchronous and clears the decoder state and the
// buffer. A stall on the output holds the buffer and stops the input.
module utf8_word_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [2:0] m_tuser,   // [0] byte_valid, [1] token_end, [2] text_end
  output logic       m_tlast
);
  import utf8wt_pkg::*;

  bundle_t   dec_bundle;
  bundle_t   buf_bundle;
  logic      buf_valid;
  logic [1:0] idx;
  logic      accept;
  logic      pop;
  logic      pop_last;
  result_t   cur;

  assign accept = s_tvalid && s_tready;

  utf8wt_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (s_tdata),
    .text_last (s_tlast),
    .bundle    (dec_bundle)
  );

  // Handshake on the result side.
  assign cur      = buf_bundle.res[idx];
  assign pop      = buf_valid && m_tready;
  assign pop_last = pop && (idx == buf_bundle.cnt - 2'd1);
  assign s_tready = !buf_valid || pop_last;

  assign m_tvalid = buf_valid;
  assign m_tdata  = cur.out_byte;
  assign m_tuser  = {cur.text_end, cur.token_end, cur.byte_valid};
  assign m_tlast  = (idx == buf_bundle.cnt - 2'd1);

  // Result buffer: load a new beat's results, step through them.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      idx <= 2'd0;
    end else if (accept && dec_bundle.cnt != 2'd0) begin
      buf_valid <= 1'b1;
      idx <= 2'd0;
    end else if (pop_last) begin
      buf_valid <= 1'b0;
      idx <= 2'd0;
    end else if (pop) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && dec_bundle.cnt != 2'd0) begin
      buf_bundle <= dec_bundle;
    end
  end

endmodule

>>> rtl/utf8wt_decode.sv
// UTF-8 decoder state, word classification, lower-casing and re-encoding.
module utf8wt_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                text_last,
  output utf8wt_pkg::bundle_t bundle
);
  import utf8wt_pkg::*;

  logic [20:0] code_accumulator, code_accumulator_next;
  logic [1:0]  bytes_remaining, bytes_remaining_next;
  logic        word_open, word_open_next;

  // Decode the byte, classify the character and build the result list.
  always_comb begin
    logic        have;
    logic [20:0] ch;
    logic [20:0] lc;
    logic        is_word;
    logic [1:0]  n;
    have = 1'b0;
    ch = '0;
    lc = '0;
    is_word = 1'b0;
    n = 2'd0;
    code_accumulator_next = code_accumulator;
    bytes_remaining_next = bytes_remaining;
    word_open_next = word_open;
    bundle = '0;

    // Continuation byte while a sequence is pending, otherwise a new lead.
    if (bytes_remaining != 2'd0 && (in_byte & CONT_MASK) == CONT_CODE) begin
      code_accumulator_next = {code_accumulator[14:0], in_byte[5:0]};
      bytes_remaining_next = bytes_remaining - 2'd1;
      if (bytes_remaining == 2'd1) begin
        have = 1'b1;
        ch = code_accumulator_next;
      end
    end else begin
      bytes_remaining_next = 2'd0;
      if (in_byte[7] == 1'b0) begin
        have = 1'b1;
        ch = {13'd0, in_byte};
      end else if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
        code_accumulator_next = {16'd0, in_byte[4:0]};
        bytes_remaining_next = 2'd1;
      end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
        code_accumulator_next = {17'd0, in_byte[3:0]};
        bytes_remaining_next = 2'd2;
      end else if ((in_byte & LEAD4_MASK) == LEAD4_CODE) begin
        code_accumulator_next = {18'd0, in_byte[2:0]};
        bytes_remaining_next = 2'd3;
      end
    end

    // Word characters: ASCII letters and digits, and the Cyrillic block.
    is_word = (ch >= 21'(8'h41) && ch <= 21'(8'h5A)) ||
              (ch >= 21'(8'h61) && ch <= 21'(8'h7A)) ||
              (ch >= 21'(8'h30) && ch <= 21'(8'h39)) ||
              (ch >= CYR_LO && ch <= CYR_HI);

    // Lower-case ASCII capitals, the Cyrillic capitals U+0410..U+042F and U+0401.
    if (ch >= 21'(8'h41) && ch <= 21'(8'h5A)) begin
      lc = ch + CASE_OFFSET;
    end else if (ch >= CYR_UP_LO && ch <= CYR_UP_HI) begin
      lc = ch + CASE_OFFSET;
    end else if (ch == CYR_IO_UP) begin
      lc = CYR_IO_LOW;
    end else begin
      lc = ch;
    end

    // Word bytes, or a closing result for a non-word character after a word.
    if (have) begin
      if (is_word) begin
        if (lc <= ASCII_MAX) begin
          bundle.res[0] = '{out_byte: lc[7:0], byte_valid: 1'b1,
                            token_end: 1'b0, text_end: 1'b0};
          n = 2'd1;
        end else begin
          bundle.res[0] = '{out_byte: {3'b110, lc[10:6]}, byte_valid: 1'b1,
                            token_end: 1'b0, text_end: 1'b0};
          bundle.res[1] = '{out_byte: {2'b10, lc[5:0]}, byte_valid: 1'b1,
                            token_end: 1'b0, text_end: 1'b0};
          n = 2'd2;
        end
        word_open_next = 1'b1;
      end else if (word_open) begin
        bundle.res[0] = '{out_byte: 8'd0, byte_valid: 1'b0,
                          token_end: 1'b1, text_end: 1'b0};
        n = 2'd1;
        word_open_next = 1'b0;
      end
    end

    // Text end: close an open word, flag the end and clear the decoder.
    if (text_last) begin
      bundle.res[n] = '{out_byte: 8'd0, byte_valid: 1'b0,
                        token_end: word_open_next, text_end: 1'b1};
      n = n + 2'd1;
      word_open_next = 1'b0;
      bytes_remaining_next = 2'd0;
      code_accumulator_next = '0;
    end

    bundle.cnt = n;
  end

  // Decoder state advances on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_accumulator <= '0;
      bytes_remaining <= 2'd0;
      word_open <= 1'b0;
    end else if (accept) begin
      code_accumulator <= code_accumulator_next;
      bytes_remaining <= bytes_remaining_next;
      word_open <= word_open_next;
    end
  end

endmodule

>>> rtl/utf8wt_checker.sv
// Port checker of the UTF-8 word tokenizer and its bind.
module utf8wt_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser,
  input logic       m_tlast
);

  // A stalled result holds its beat.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                               && $stable(m_tlast))
    else $error("result beat changed under stall");

  // A closing result never carries a byte.
  a_close_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0])
    else $error("closing result carries a byte");

  // The text end is always the last result of its input beat.
  a_text_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tlast)
    else $error("text end not on the last result of its beat");

  // A result without a byte carries a zero data byte.
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
    else $error("nonzero data on a result without a byte");

  // Nothing is offered in the cycle after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

endmodule

bind utf8_word_tokenizer utf8wt_checker u_utf8wt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
